[sv/kibs_pkg.sv]
// shared types and constants for the key and index block sorter
package kibs_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned GroupN = 4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRESORT,
    ST_MERGE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load_en;
    logic presort_start;
    logic merge_start;
    logic emit_start;
  } cmd_t;

  typedef struct packed {
    logic chunk_done;
    logic presort_done;
    logic merge_done;
    logic emit_done;
  } status_t;

endpackage

[sv/kibs_ctrl.sv]
// sequencer for load, presort, merge and emit phases
module kibs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kibs_pkg::status_t status_i,
  output kibs_pkg::cmd_t    cmd_o
);
  import kibs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:    if (status_i.chunk_done) state_d = ST_PRESORT;
      ST_PRESORT: if (status_i.presort_done) state_d = ST_MERGE;
      ST_MERGE:   if (status_i.merge_done) state_d = ST_EMIT;
      ST_EMIT:    if (status_i.emit_done) state_d = ST_LOAD;
      default:    state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_LOAD:    cmd_o.load_en = 1'b1;
      ST_PRESORT: cmd_o.presort_start = 1'b1;
      ST_MERGE:   cmd_o.merge_start = 1'b1;
      ST_EMIT:    cmd_o.emit_start = 1'b1;
      default:    cmd_o = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(cmd_o)) else $error("command not one-hot");
  a_load_to_presort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && status_i.chunk_done) |=> state_q == ST_PRESORT)
    else $error("chunk close not followed by presort");
  a_emit_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && status_i.emit_done) |=> state_q == ST_LOAD)
    else $error("emit end not followed by load");
`endif

endmodule

[sv/kibs_datapath.sv]
// store, presort, merge and emit datapath
module kibs_datapath #(
  parameter int unsigned Depth = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kibs_pkg::cmd_t          cmd_i,
  output kibs_pkg::status_t       status_o,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [kibs_pkg::KeyW-1:0] in_key_i,
  input  logic [kibs_pkg::IdxW-1:0] in_idx_i,
  input  logic                    in_last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [kibs_pkg::KeyW-1:0] out_key_o,
  output logic [kibs_pkg::IdxW-1:0] out_idx_o,
  output logic                    out_last_o
);
  import kibs_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned MW = AW + 1;

  // sub-phases of the presort and merge sequencers
  localparam logic [2:0] PhRead   = 3'd0;
  localparam logic [2:0] PhInsert = 3'd1;
  localparam logic [2:0] PhMerge  = 3'd2;
  localparam logic [2:0] PhWrite  = 3'd3;
  localparam logic [2:0] PhSetup  = 3'd4;

  typedef logic [KeyW+IdxW-1:0] ent_t;

  // two banks, ping-pong
  ent_t mem0 [Depth];
  ent_t mem1 [Depth];

  logic [CW-1:0] fill_q;
  logic [CW-1:0] n_q;
  logic          bank_q;

  // write port
  logic          we0, we1;
  logic [AW-1:0] wa;
  ent_t          wd;
  // read ports
  logic [AW-1:0] ra_a, ra_b;
  ent_t          rd0_a, rd0_b, rd1_a, rd1_b;

  always_ff @(posedge clk_i) begin
    if (we0) mem0[wa] <= wd;
    if (we1) mem1[wa] <= wd;
    rd0_a <= mem0[ra_a];
    rd0_b <= mem0[ra_b];
    rd1_a <= mem1[ra_a];
    rd1_b <= mem1[ra_b];
  end

  wire ent_t rda = bank_q ? rd1_a : rd0_a;
  wire ent_t rdb = bank_q ? rd1_b : rd0_b;

  // load
  logic acc_in, add_in, close_in;
  assign in_ready_o = cmd_i.load_en && !status_o.chunk_done;
  assign acc_in     = in_valid_i && in_ready_o;
  assign add_in     = acc_in && (in_key_i != '0);
  assign close_in   = acc_in && (in_last_i || (add_in && fill_q == CW'(Depth - 1)));

  // sequencer counters
  logic [2:0]    ph_q;
  logic [MW:0]   step_q;
  logic [MW:0]   a_q, i1_q, i2_q, e1_q, e2_q, o_q;
  logic [1:0]    gp_q;
  ent_t          g_q [GroupN];
  logic [CW-1:0] em_q;
  logic          busy_q;

  function automatic logic [MW:0] minv(logic [MW:0] x, logic [MW:0] y);
    return (x < y) ? x : y;
  endfunction

  logic [MW:0] nn;
  assign nn = (MW+1)'(n_q);

  // output register
  logic ov_q;
  ent_t od_q;
  logic ol_q;
  assign out_valid_o = ov_q;
  assign out_key_o   = od_q[KeyW+IdxW-1:IdxW];
  assign out_idx_o   = od_q[IdxW-1:0];
  assign out_last_o  = ol_q;

  // merge compare on registered reads
  logic take1;
  assign take1 = (i2_q >= e2_q) ||
                 ((i1_q < e1_q) && (rda[KeyW+IdxW-1:IdxW] < rdb[KeyW+IdxW-1:IdxW]));

  always_comb begin
    we0 = 1'b0; we1 = 1'b0; wa = '0; wd = '0;
    ra_a = i1_q[AW-1:0]; ra_b = i2_q[AW-1:0];
    if (cmd_i.load_en) begin
      we0 = add_in; wa = fill_q[AW-1:0]; wd = {in_key_i, in_idx_i};
      ra_a = '0; ra_b = '0;
    end else if (cmd_i.presort_start) begin
      ra_a = AW'(a_q + (MW+1)'(gp_q)); ra_b = ra_a;
      if (ph_q == PhWrite) begin
        we0 = 1'b1; wa = AW'(a_q + (MW+1)'(gp_q)); wd = g_q[gp_q];
      end
    end else if (cmd_i.merge_start) begin
      if (ph_q == PhMerge) begin
        we0 = bank_q; we1 = !bank_q; wa = o_q[AW-1:0];
        wd = take1 ? rda : rdb;
      end
    end else if (cmd_i.emit_start) begin
      ra_a = em_q[AW-1:0]; ra_b = ra_a;
    end
  end

  // insertion of one word into the sorted group buffer (stable)
  function automatic void ins(input ent_t x, input logic [1:0] cnt,
                              inout ent_t g [GroupN]);
    logic [1:0] p;
    p = cnt;
    for (int k = GroupN - 1; k > 0; k--) begin
      if (2'(k) <= cnt && g[k-1][KeyW+IdxW-1:IdxW] > x[KeyW+IdxW-1:IdxW]) begin
        g[k] = g[k-1];
        p = 2'(k - 1);
      end
    end
    g[p] = x;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0; n_q <= '0; bank_q <= 1'b0; ph_q <= PhRead; step_q <= '0;
      a_q <= '0; i1_q <= '0; i2_q <= '0; e1_q <= '0; e2_q <= '0; o_q <= '0;
      gp_q <= '0; em_q <= '0; busy_q <= 1'b0; ov_q <= 1'b0; ol_q <= 1'b0;
      status_o <= '0;
    end else begin
      status_o <= '0;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (cmd_i.load_en) begin
        if (add_in) fill_q <= fill_q + CW'(1);
        if (close_in) begin
          n_q <= add_in ? fill_q + CW'(1) : fill_q;
          fill_q <= '0;
          if (fill_q != '0 || add_in) status_o.chunk_done <= 1'b1;
        end
        a_q <= '0; gp_q <= '0; ph_q <= PhRead; bank_q <= 1'b0;
      end else if (cmd_i.presort_start && !status_o.presort_done) begin
        // read: issue read, insert: sort into group, write: write back
        case (ph_q)
          PhRead: ph_q <= PhInsert;
          PhInsert: begin
            ins(rda, gp_q, g_q);
            if (gp_q == 2'd3 || a_q + (MW+1)'(gp_q) + 1 >= nn) begin
              gp_q <= '0; ph_q <= PhWrite;
            end else begin
              gp_q <= gp_q + 2'd1; ph_q <= PhRead;
            end
          end
          PhWrite: begin
            if (gp_q == 2'd3 || a_q + (MW+1)'(gp_q) + 1 >= nn) begin
              gp_q <= '0; ph_q <= PhRead;
              a_q <= a_q + (MW+1)'(GroupN);
              if (a_q + (MW+1)'(GroupN) >= nn) begin
                status_o.presort_done <= 1'b1;
                step_q <= (MW+1)'(GroupN); a_q <= '0; ph_q <= PhSetup;
              end
            end else gp_q <= gp_q + 2'd1;
          end
          default: ph_q <= PhRead;
        endcase
      end else if (cmd_i.merge_start && !status_o.merge_done) begin
        // setup: set up pair, read: wait read, merge: write one word
        case (ph_q)
          PhSetup: begin
            if (step_q >= nn) begin
              status_o.merge_done <= 1'b1; em_q <= '0; busy_q <= 1'b0;
            end else begin
              i1_q <= a_q; e1_q <= minv(a_q + step_q, nn); i2_q <= minv(a_q + step_q, nn);
              e2_q <= minv(a_q + (step_q << 1), nn); o_q <= a_q; ph_q <= PhRead;
            end
          end
          PhRead: ph_q <= PhMerge;
          PhMerge: begin
            if (take1) i1_q <= i1_q + 1'b1; else i2_q <= i2_q + 1'b1;
            o_q <= o_q + 1'b1;
            ph_q <= PhRead;
            if (o_q + 1'b1 >= e2_q) begin
              ph_q <= PhSetup;
              if (a_q + (step_q << 1) >= nn) begin
                a_q <= '0; step_q <= step_q << 1; bank_q <= !bank_q;
              end else a_q <= a_q + (step_q << 1);
            end
          end
          default: ph_q <= PhSetup;
        endcase
      end else if (cmd_i.emit_start && !status_o.emit_done) begin
        // busy_q: read pending
        if (!busy_q && (!ov_q || out_ready_i)) busy_q <= 1'b1;
        else if (busy_q && (!ov_q || out_ready_i)) begin
          ov_q <= 1'b1; od_q <= rda;
          ol_q <= (em_q + CW'(1) == n_q);
          busy_q <= 1'b0; em_q <= em_q + CW'(1);
          if (em_q + CW'(1) == n_q) status_o.emit_done <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CW'(Depth)) else $error("fill count overflow");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load_en |-> !in_ready_o) else $error("input taken while sorting");
  a_last_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ol_q && out_ready_i) |=> !(ov_q && ol_q) || $past(status_o.emit_done))
    else $error("repeated last word");
`endif

endmodule

[sv/key_index_block_sorter.sv]
// Top level of the key and index block sorter. Words are loaded at one per
// cycle into a two-bank store until a tlast word arrives or Depth entries are
// held (zero keys are dropped). The chunk of n entries is then sorted: groups
// of four are insertion sorted, then merge rounds over the two banks follow,
// ceil(log2(n/4)) of them. Results leave through an output register, one at
// a time, each read from the store first. Input is stalled from chunk close
// until the last result has been placed in the output register; a full chunk
// at the default depth takes four merge rounds.
module key_index_block_sorter #(
  parameter int unsigned Depth = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // entry_key, entry_index
  input  logic        s_axis_tlast,   // chunk_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // sorted_key, sorted_index
  output logic        m_axis_tlast    // run_last
);
  import kibs_pkg::*;

  cmd_t    cmd;
  status_t status;

  kibs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  kibs_datapath #(.Depth(Depth)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_key_i    (s_axis_tdata[63:0]),
    .in_idx_i    (s_axis_tdata[79:64]),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_key_o   (m_axis_tdata[63:0]),
    .out_idx_o   (m_axis_tdata[79:64]),
    .out_last_o  (m_axis_tlast)
  );

endmodule
